// ===== rtl/gelu_tanh_activation_assert.svh =====
// assertion macros for the gelu activation block
// depends on nothing; taken in by the files that check their own logic
`ifndef GELU_TANH_ACTIVATION_ASSERT_SVH
`define GELU_TANH_ACTIVATION_ASSERT_SVH
`ifndef SYNTHESIS
`define GELU_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GELU_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define GELU_ASSERT(label, clk, rst_n, prop, msg)
`define GELU_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// ===== rtl/gelu_pkg.sv =====
// widths, constants and latencies shared by the gelu activation pipeline
// depends on nothing
package gelu_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 12;

    localparam int QF   = 24;
    localparam int M_W  = 28;
    localparam int M2_W = 31;
    localparam int M3_W = 34;
    localparam int IN_W = 29;
    localparam int A2_W = 30;
    localparam int R_W  = 24;
    localparam int K_W  = 6;
    localparam int H_W  = QF + 1;
    localparam int D_W  = QF + 2;

    localparam logic [H_W-1:0]  Q_ONE   = {1'b1, {QF{1'b0}}};
    localparam logic [19:0]     C_CUBIC = 20'd750193;
    localparam logic [23:0]     C_SQ2PI = 24'd13386282;
    localparam logic [23:0]     C_LN2   = 24'd11629080;
    localparam logic [IN_W-1:0] A_MAX   = 29'h1000_0000;

    localparam logic [8:0] LN2_RECIP = 9'd369;
    localparam int         LN2_SHIFT = 32;

    localparam int HORNER_STEPS = 6;
    localparam int RECIP_SHIFT  = 26;
    localparam int RC_W         = RECIP_SHIFT + 1;

    localparam int FRONT_LAT     = 7;
    localparam int EXP_LAT       = 3 + 3 * HORNER_STEPS + 1;
    localparam int DIV_LAT       = 1 + H_W;
    localparam int SIDE_LAT      = FRONT_LAT + EXP_LAT + DIV_LAT;
    localparam int START_TO_DONE = SIDE_LAT + 4;

    // floor(2^26 / n) for the horner divisor of each step
    function automatic logic [RC_W-1:0] horner_recip(input int step);
        logic [RC_W-1:0] rc;
        case (step)
            0:       rc = 27'd11184810;
            1:       rc = 27'd13421772;
            2:       rc = 27'd16777216;
            3:       rc = 27'd22369621;
            4:       rc = 27'd33554432;
            default: rc = 27'd67108864;
        endcase
        return rc;
    endfunction

    function automatic logic [2:0] horner_div(input int step);
        return 3'(HORNER_STEPS - step);
    endfunction

endpackage

// ===== rtl/gelu_front.sv =====
// front of the gelu pipeline: clamp, cubic term and tanh argument, doubled
// depends on gelu_pkg
module gelu_front import gelu_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [DATA_WIDTH-1:0] mag,
    output logic                  out_valid,
    output logic [A2_W-1:0]       two_a
);

    localparam int SHIFT = QF - FRAC_BITS;
    localparam int CMP_W = (DATA_WIDTH > FRAC_BITS + 4) ? DATA_WIDTH : FRAC_BITS + 4;
    localparam logic [CMP_W-1:0] BOUND = CMP_W'(8) << FRAC_BITS;

    logic [FRONT_LAT-1:0] vld_reg;

    logic [CMP_W-1:0]      mag_ext;
    logic [CMP_W-1:0]      clamp;
    logic [M_W-1:0]        m_next;
    logic [M_W-1:0]        m_p1_reg;
    logic [M_W-1:0]        m_p2_reg;
    logic [M_W-1:0]        m_p3_reg;
    logic [M_W-1:0]        m_p4_reg;
    logic [2*M_W-1:0]      sq;
    logic [M2_W-1:0]       m2_reg;
    logic [M2_W+M_W-1:0]   cu;
    logic [M3_W-1:0]       m3_reg;
    logic [M3_W+19:0]      pc;
    logic [IN_W-1:0]       cub_reg;
    logic [IN_W-1:0]       inner_next;
    logic [IN_W-1:0]       inner_reg;
    logic [IN_W+23:0]      pa;
    logic [IN_W-1:0]       araw_reg;
    logic [IN_W-1:0]       a_clamp;
    logic [A2_W-1:0]       two_a_reg;

    // clamp to 8.0 and rescale to q24
    assign mag_ext = CMP_W'(mag);
    assign clamp   = (mag_ext > BOUND) ? BOUND : mag_ext;
    assign m_next  = M_W'(clamp) << SHIFT;

    assign sq         = m_p1_reg * m_p1_reg;
    assign cu         = m2_reg * m_p2_reg;
    assign pc         = m3_reg * C_CUBIC;
    assign inner_next = IN_W'(m_p4_reg) + cub_reg;
    assign pa         = inner_reg * C_SQ2PI;
    assign a_clamp    = (araw_reg > A_MAX) ? A_MAX : araw_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[FRONT_LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        m_p1_reg  <= m_next;
        m2_reg    <= sq[QF +: M2_W];
        m_p2_reg  <= m_p1_reg;
        m3_reg    <= cu[QF +: M3_W];
        m_p3_reg  <= m_p2_reg;
        cub_reg   <= pc[QF +: IN_W];
        m_p4_reg  <= m_p3_reg;
        inner_reg <= inner_next;
        araw_reg  <= pa[QF +: IN_W];
        two_a_reg <= {a_clamp, 1'b0};
    end

    assign out_valid = vld_reg[FRONT_LAT-1];
    assign two_a     = two_a_reg;

endmodule

// ===== rtl/gelu_exp.sv =====
// exp(-2a) unit: ln2 range reduction, six-step horner chain, final shift
// depends on gelu_pkg
module gelu_exp import gelu_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [A2_W-1:0] two_a,
    output logic            out_valid,
    output logic [H_W-1:0]  e
);

    localparam int KP_W = A2_W + 9;
    localparam int RH_W = R_W + H_W;
    localparam int VQ_W = R_W + RC_W;

    logic            v1_reg;
    logic            v2_reg;
    logic            v3_reg;
    logic            ve_reg;
    logic [KP_W-1:0] kp;
    logic [K_W-1:0]  k1_reg;
    logic [A2_W-1:0] ta1_reg;
    logic [A2_W-1:0] kl;
    logic [A2_W-1:0] r0_full;
    logic [R_W:0]    r0_reg;
    logic [K_W-1:0]  k2_reg;
    logic [R_W-1:0]  r3_reg;
    logic [K_W-1:0]  k3_reg;
    logic [R_W-1:0]  r3_next;
    logic [K_W-1:0]  k3_next;
    logic [H_W-1:0]  e_next;
    logic [H_W-1:0]  e_reg;

    logic           va_reg [HORNER_STEPS];
    logic           vb_reg [HORNER_STEPS];
    logic           vc_reg [HORNER_STEPS];
    logic [R_W-1:0] pa_v_reg [HORNER_STEPS];
    logic [R_W-1:0] pb_v_reg [HORNER_STEPS];
    logic [R_W-1:0] qe_reg [HORNER_STEPS];
    logic [H_W-1:0] h_reg [HORNER_STEPS];
    logic [R_W-1:0] ra_reg [HORNER_STEPS];
    logic [R_W-1:0] rb_reg [HORNER_STEPS];
    logic [R_W-1:0] rc_reg [HORNER_STEPS];
    logic [K_W-1:0] ka_reg [HORNER_STEPS];
    logic [K_W-1:0] kb_reg [HORNER_STEPS];
    logic [K_W-1:0] kc_reg [HORNER_STEPS];

    // k estimate from the reciprocal of ln2, at most one short
    assign kp      = two_a * LN2_RECIP;
    assign kl      = A2_W'(k1_reg) * A2_W'(C_LN2);
    assign r0_full = ta1_reg - kl;
    assign r3_next = (r0_reg >= {1'b0, C_LN2}) ? R_W'(r0_reg - {1'b0, C_LN2})
                                              : r0_reg[R_W-1:0];
    assign k3_next = (r0_reg >= {1'b0, C_LN2}) ? k2_reg + 1'b1 : k2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        k1_reg  <= kp[LN2_SHIFT +: K_W];
        ta1_reg <= two_a;
        r0_reg  <= r0_full[R_W:0];
        k2_reg  <= k1_reg;
        r3_reg  <= r3_next;
        k3_reg  <= k3_next;
    end

    for (genvar s = 0; s < HORNER_STEPS; s++)
    begin : g_step
        logic            vin;
        logic [R_W-1:0]  rin;
        logic [K_W-1:0]  kin;
        logic [H_W-1:0]  hin;
        logic [RH_W-1:0] rh;
        logic [VQ_W-1:0] vq;
        logic [R_W+2:0]  qn;
        logic [R_W+2:0]  rem;
        logic [R_W-1:0]  q;
        logic [H_W-1:0]  h_next;

        if (s == 0)
        begin : g_first
            assign vin = v3_reg;
            assign rin = r3_reg;
            assign kin = k3_reg;
            assign hin = Q_ONE;
        end
        else
        begin : g_chain
            assign vin = vc_reg[s-1];
            assign rin = rc_reg[s-1];
            assign kin = kc_reg[s-1];
            assign hin = h_reg[s-1];
        end

        assign rh     = rin * hin;
        assign vq     = pa_v_reg[s] * horner_recip(s);
        assign qn     = (R_W+3)'(qe_reg[s]) * (R_W+3)'(horner_div(s));
        assign rem    = {3'b000, pb_v_reg[s]} - qn;
        assign q      = (rem >= (R_W+3)'(horner_div(s))) ? qe_reg[s] + 1'b1 : qe_reg[s];
        assign h_next = Q_ONE - H_W'(q);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                va_reg[s] <= 1'b0;
                vb_reg[s] <= 1'b0;
                vc_reg[s] <= 1'b0;
            end
            else
            begin
                va_reg[s] <= vin;
                vb_reg[s] <= va_reg[s];
                vc_reg[s] <= vb_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            pa_v_reg[s] <= rh[QF +: R_W];
            ra_reg[s]   <= rin;
            ka_reg[s]   <= kin;
            qe_reg[s]   <= vq[RECIP_SHIFT +: R_W];
            pb_v_reg[s] <= pa_v_reg[s];
            rb_reg[s]   <= ra_reg[s];
            kb_reg[s]   <= ka_reg[s];
            h_reg[s]    <= h_next;
            rc_reg[s]   <= rb_reg[s];
            kc_reg[s]   <= kb_reg[s];
        end
    end

    // scale by 2^-k
    assign e_next = (kc_reg[HORNER_STEPS-1] >= K_W'(H_W)) ? '0
                  : (h_reg[HORNER_STEPS-1] >> kc_reg[HORNER_STEPS-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ve_reg <= 1'b0;
        end
        else
        begin
            ve_reg <= vc_reg[HORNER_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg <= e_next;
    end

    assign out_valid = ve_reg;
    assign e         = e_reg;

endmodule

// ===== rtl/gelu_div.sv =====
// tanh from e: (1 - e) / (1 + e) in q24 by a restoring divider, one bit a stage
// depends on gelu_pkg
module gelu_div import gelu_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [H_W-1:0] e,
    output logic           out_valid,
    output logic [H_W-1:0] t
);

    logic           v0_reg;
    logic [D_W-1:0] num0_reg;
    logic [D_W-1:0] den0_reg;

    logic           dv_reg [H_W];
    logic [D_W-1:0] rem_reg [H_W];
    logic [D_W-1:0] den_reg [H_W];
    logic [H_W-1:0] q_reg [H_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        num0_reg <= D_W'(Q_ONE - e);
        den0_reg <= D_W'(Q_ONE) + D_W'(e);
    end

    for (genvar j = 0; j < H_W; j++)
    begin : g_bit
        logic           vin;
        logic [D_W-1:0] din;
        logic [H_W-1:0] qin;
        logic [D_W-1:0] sh;
        logic           ge;

        if (j == 0)
        begin : g_first
            assign vin = v0_reg;
            assign din = den0_reg;
            assign qin = '0;
            assign sh  = num0_reg;
        end
        else
        begin : g_chain
            logic [D_W-1:0] rin;

            assign vin = dv_reg[j-1];
            assign din = den_reg[j-1];
            assign qin = q_reg[j-1];
            assign rin = rem_reg[j-1];
            assign sh  = {rin[D_W-2:0], 1'b0};
        end

        assign ge = (sh >= din);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[j] <= 1'b0;
            end
            else
            begin
                dv_reg[j] <= vin;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j] <= ge ? sh - din : sh;
            den_reg[j] <= din;
            q_reg[j]   <= {qin[H_W-2:0], ge};
        end
    end

    assign out_valid = dv_reg[H_W-1];
    assign t         = q_reg[H_W-1];

endmodule

// ===== rtl/gelu_tanh_activation.sv =====
// top level of the gelu activation, tanh form, fixed point
// depends on gelu_pkg, gelu_front, gelu_exp, gelu_div and the assertion header
//
// channel   ports                       transfer
// input     start, busy, x, last_in     word taken when start && !busy
// result    done, y, last_out           one-cycle strobe per word
//
// one word per cycle; busy never rises, nothing stalls
// path from the accepting edge to the edge that takes the result:
// 7-stage cubic front, 22-stage exp unit (three stages per horner step), 26-stage
// divider, a quotient bit per stage but the first, plus input and three output stages
// reset clears the valid bits only; the receiver cannot hold results off
module gelu_tanh_activation import gelu_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [DATA_WIDTH-1:0] x,
    input  logic                         last_in,
    output logic                         done,
    output logic signed [DATA_WIDTH-1:0] y,
    output logic                         last_out
);

    localparam int PW = DATA_WIDTH + H_W;
    localparam logic signed [DATA_WIDTH+1:0] YMAX = {3'b000, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH+1:0] YMIN = {3'b111, {(DATA_WIDTH-1){1'b0}}};

    logic                  s0_valid_reg;
    logic [DATA_WIDTH-1:0] xu;
    logic [DATA_WIDTH-1:0] mag_next;
    logic [DATA_WIDTH-1:0] mag_reg;
    logic                  neg_reg;
    logic                  last_reg;

    logic [DATA_WIDTH-1:0] side_mag_reg [SIDE_LAT];
    logic                  side_neg_reg [SIDE_LAT];
    logic                  side_last_reg [SIDE_LAT];

    logic                  fr_valid;
    logic [A2_W-1:0]       fr_two_a;
    logic                  ex_valid;
    logic [H_W-1:0]        ex_e;
    logic                  dv_valid;
    logic [H_W-1:0]        dv_t;

    logic [D_W-1:0]        cdf_sum;
    logic [H_W-1:0]        cdf_next;
    logic                  o1_valid_reg;
    logic [H_W-1:0]        cdf_reg;
    logic [DATA_WIDTH-1:0] o1_mag_reg;
    logic                  o1_neg_reg;
    logic                  o1_last_reg;

    logic [PW-1:0]         prod;
    logic                  o2_valid_reg;
    logic [DATA_WIDTH:0]   ym_reg;
    logic [DATA_WIDTH-1:0] o2_mag_reg;
    logic                  o2_neg_reg;
    logic                  o2_last_reg;

    logic signed [DATA_WIDTH+1:0] ys;
    logic signed [DATA_WIDTH+1:0] ysat;
    logic                         done_reg;
    logic [DATA_WIDTH-1:0]        y_reg;
    logic                         last_out_reg;

    assign busy     = 1'b0;
    assign xu       = x;
    assign mag_next = xu[DATA_WIDTH-1] ? (~xu + 1'b1) : xu;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        neg_reg  <= xu[DATA_WIDTH-1];
        last_reg <= last_in;
    end

    // sign, magnitude and last flag ride alongside the arithmetic
    always_ff @(posedge clk)
    begin
        side_mag_reg[0]  <= mag_reg;
        side_neg_reg[0]  <= neg_reg;
        side_last_reg[0] <= last_reg;
        for (int i = 1; i < SIDE_LAT; i++)
        begin
            side_mag_reg[i]  <= side_mag_reg[i-1];
            side_neg_reg[i]  <= side_neg_reg[i-1];
            side_last_reg[i] <= side_last_reg[i-1];
        end
    end

    gelu_front #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s0_valid_reg),
        .mag       (mag_reg),
        .out_valid (fr_valid),
        .two_a     (fr_two_a)
    );

    gelu_exp u_exp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .two_a     (fr_two_a),
        .out_valid (ex_valid),
        .e         (ex_e)
    );

    gelu_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ex_valid),
        .e         (ex_e),
        .out_valid (dv_valid),
        .t         (dv_t)
    );

    assign cdf_sum  = side_neg_reg[SIDE_LAT-1] ? D_W'(Q_ONE) - D_W'(dv_t)
                                               : D_W'(Q_ONE) + D_W'(dv_t);
    assign cdf_next = cdf_sum[H_W:1];

    assign prod = PW'(o1_mag_reg) * PW'(cdf_reg) + (PW'(1) << (QF - 1));

    assign ys   = o2_neg_reg ? -$signed({1'b0, ym_reg}) : $signed({1'b0, ym_reg});
    assign ysat = (ys > YMAX) ? YMAX : ((ys < YMIN) ? YMIN : ys);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o1_valid_reg <= 1'b0;
            o2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            o1_valid_reg <= dv_valid;
            o2_valid_reg <= o1_valid_reg;
            done_reg     <= o2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cdf_reg      <= cdf_next;
        o1_mag_reg   <= side_mag_reg[SIDE_LAT-1];
        o1_neg_reg   <= side_neg_reg[SIDE_LAT-1];
        o1_last_reg  <= side_last_reg[SIDE_LAT-1];
        ym_reg       <= prod[QF +: DATA_WIDTH+1];
        o2_mag_reg   <= o1_mag_reg;
        o2_neg_reg   <= o1_neg_reg;
        o2_last_reg  <= o1_last_reg;
        y_reg        <= ysat[DATA_WIDTH-1:0];
        last_out_reg <= o2_last_reg;
    end

    assign done     = done_reg;
    assign y        = y_reg;
    assign last_out = last_out_reg;

`include "gelu_tanh_activation_assert.svh"

    `GELU_ASSERT(a_word_latency, clk, rst_n, (start && !busy) |-> ##START_TO_DONE done, "accepted word did not come out on time")
    `GELU_ASSERT(a_cdf_range, clk, rst_n, o1_valid_reg |-> (cdf_reg <= Q_ONE), "cdf above one")
    `GELU_ASSERT(a_mag_bound, clk, rst_n, o2_valid_reg |-> (ym_reg <= {1'b0, o2_mag_reg}), "result magnitude above input")
    `GELU_ASSERT(a_pos_sign, clk, rst_n, (o2_valid_reg && !o2_neg_reg) |=> (y >= 0), "negative result for positive input")

endmodule

// ===== verif/gelu_result_checker.sv =====
`timescale 1ns / 1ps
// checker for the gelu activation block: predicts the result of every word
// taken on the input channel and compares it with the strobed result
// depends on gelu_pkg for the default widths
module gelu_result_checker import gelu_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic signed [DATA_WIDTH-1:0] x,
    input  logic                         last_in,
    input  logic                         done,
    input  logic signed [DATA_WIDTH-1:0] y,
    input  logic                         last_out,
    output int                           fail_count,
    output int                           pending
);

    localparam logic [63:0] ONE_Q24   = 64'd1 << 24;
    localparam logic [63:0] CUBIC_Q24 = 64'd750193;
    localparam logic [63:0] SQ2PI_Q24 = 64'd13386282;
    localparam logic [63:0] LN2_Q24   = 64'd11629080;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] sample;
        logic [DATA_WIDTH-1:0] gelu;
        logic                  last;
    } gelu_word_t;

    gelu_word_t expected_words[$];
    int         failures    = 0;
    int         outstanding = 0;

    assign fail_count = failures;
    assign pending    = outstanding;

    // tanh of a nonnegative q24 argument via exp(-2a) split into 2^-k * exp(-r)
    function automatic logic [63:0] tanh_q24(input logic [63:0] arg);
        logic [63:0] a;
        logic [63:0] two_a;
        logic [63:0] k;
        logic [63:0] r;
        logic [63:0] h;
        logic [63:0] e;
        a     = (arg > 16 * ONE_Q24) ? 16 * ONE_Q24 : arg;
        two_a = 2 * a;
        k     = two_a / LN2_Q24;
        r     = two_a - k * LN2_Q24;
        h     = ONE_Q24;
        for (int n = 6; n >= 1; n--)
        begin
            h = ONE_Q24 - (((r * h) >> 24) / 64'(n));
        end
        e = (k >= 64'd63) ? 64'd0 : (h >> k);
        if (e > ONE_Q24)
        begin
            e = ONE_Q24;
        end
        return ((ONE_Q24 - e) * ONE_Q24) / (ONE_Q24 + e);
    endfunction

    function automatic logic [DATA_WIDTH-1:0] predict_gelu(input logic [DATA_WIDTH-1:0] sample);
        logic [63:0] sign_bit;
        logic [63:0] mask;
        logic [63:0] bound;
        logic [63:0] mag;
        logic [63:0] m;
        logic [63:0] m2;
        logic [63:0] m3;
        logic [63:0] inner;
        logic [63:0] a;
        logic [63:0] t;
        logic [63:0] cdf;
        logic [63:0] ym;
        logic        neg;
        longint      y_s;
        longint      y_max;
        longint      y_min;
        sign_bit = 64'd1 << (DATA_WIDTH - 1);
        mask     = (64'd1 << DATA_WIDTH) - 64'd1;
        bound    = 64'd8 << FRAC_BITS;
        neg      = sample[DATA_WIDTH-1];
        mag      = 64'(sample);
        if (neg)
        begin
            mag = (~mag + 64'd1) & mask;
            if (mag == 64'd0)
            begin
                mag = sign_bit;
            end
        end
        m     = (mag > bound) ? bound : mag;
        m     = m << (24 - FRAC_BITS);
        m2    = (m * m) >> 24;
        m3    = (m2 * m) >> 24;
        inner = m + ((m3 * CUBIC_Q24) >> 24);
        a     = (inner * SQ2PI_Q24) >> 24;
        t     = tanh_q24(a);
        cdf   = neg ? ((ONE_Q24 - t) >> 1) : ((ONE_Q24 + t) >> 1);
        ym    = (mag * cdf + (64'd1 << 23)) >> 24;
        y_s   = neg ? -longint'(ym) : longint'(ym);
        y_max = longint'(sign_bit) - 1;
        y_min = -longint'(sign_bit);
        if (y_s > y_max)
        begin
            y_s = y_max;
        end
        if (y_s < y_min)
        begin
            y_s = y_min;
        end
        return y_s[DATA_WIDTH-1:0];
    endfunction

    always @(posedge clk)
    begin
        gelu_word_t want;
        gelu_word_t taken;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_words.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                    begin
                        $display("unexpected result word: y=%h last=%b", y, last_out);
                    end
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (y !== want.gelu || last_out !== want.last)
                    begin
                        failures++;
                        if (failures <= 10)
                        begin
                            $display("mismatch for x=%h: expected y=%h last=%b, got y=%h last=%b",
                                     want.sample, want.gelu, want.last, y, last_out);
                        end
                    end
                end
            end
            if (start && !busy)
            begin
                taken.sample = x;
                taken.gelu   = predict_gelu(x);
                taken.last   = last_in;
                expected_words.push_back(taken);
            end
            outstanding <= expected_words.size();
        end
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// top of the gelu activation testbench: clock, reset, stimulus and verdict
// depends on gelu_pkg, gelu_tanh_activation and gelu_result_checker
module testbench;
    import gelu_pkg::*;

    localparam int DW          = DATA_WIDTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_WORDS = 225;

    logic          clk     = 1'b0;
    logic          rst_n   = 1'b0;
    logic          start   = 1'b0;
    logic [DW-1:0] x       = '0;
    logic          last_in = 1'b0;
    logic          busy;
    logic          done;
    logic [DW-1:0] y;
    logic          last_out;
    int            fail_count;
    int            pending;
    int            cycles  = 0;

    always #4 clk = ~clk;

    gelu_tanh_activation i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .x        (x),
        .last_in  (last_in),
        .done     (done),
        .y        (y),
        .last_out (last_out)
    );

    gelu_result_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .x          (x),
        .last_in    (last_in),
        .done       (done),
        .y          (y),
        .last_out   (last_out),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_word(input logic [DW-1:0] sample, input logic last);
        start   <= 1'b1;
        x       <= sample;
        last_in <= last;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    task automatic idle_gap(input int pct);
        while (int'($urandom_range(99)) < pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // full range, mid range, within plus or minus one, and words near both ends of the range
    function automatic logic [DW-1:0] random_sample();
        int v;
        case ($urandom_range(3))
            0:       v = $urandom;
            1:       v = int'($urandom_range(32767)) - 16384;
            2:       v = int'($urandom_range(8191)) - 4096;
            default: v = $urandom_range(1) ? int'($urandom_range(32767, 32700))
                                           : -int'($urandom_range(32768, 32700));
        endcase
        return v[DW-1:0];
    endfunction

    initial
    begin
        logic [DW-1:0] directed[20] = '{
            16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000,
            16'h8001, 16'h1000, 16'hF000, 16'h0800, 16'hF800,
            16'h3000, 16'hD000, 16'h7000, 16'h9000, 16'h03E8,
            16'hFC18, 16'h5555, 16'hAAAA, 16'h4E20, 16'hB1E0
        };
        int idle_pct[4] = '{0, 63, 0, 25};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            send_word(directed[i], (i % 3) == 2);
        end

        foreach (idle_pct[p])
        begin
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                idle_gap(idle_pct[p]);
                send_word(random_sample(), $urandom_range(15) == 0);
            end
        end
        send_word(random_sample(), 1'b1);
        start <= 1'b0;

        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (START_TO_DONE + 10) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
